FILE: rtl/sample_loop_address_gen_macros.svh
// assertion macros for the sample loop address generator
// used by sample_loop_address_gen.sv, no other dependencies
`ifndef SAMPLE_LOOP_ADDRESS_GEN_MACROS_SVH
`define SAMPLE_LOOP_ADDRESS_GEN_MACROS_SVH

// consequent checked in the same cycle
`define SLAG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define SLAG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/slag_pkg.sv
// shared constants for the sample loop address generator
// no dependencies
package slag_pkg;

   localparam int ADDR_BITS_DEFAULT  = 24;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CHANNEL_BITS       = 4;
   localparam int MODE_BITS          = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_MODE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_START    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_END      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_SIZE     = 3'd4;

   localparam logic [MODE_BITS-1:0] LOOP_NONE     = 2'd0;
   localparam logic [MODE_BITS-1:0] LOOP_JUMP     = 2'd1;
   localparam logic [MODE_BITS-1:0] LOOP_PINGPONG = 2'd2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [CHANNEL_BITS-1:0] CHANNEL_COUNT_RESET = 4'd1;

endpackage

FILE: rtl/sample_loop_address_gen.sv
// sample loop address generator: one sample address per step transaction while samples are left
// latency: a result is registered and offered the cycle after its step is accepted
// throughput: one transaction per cycle unless req_stall is high, i.e. a result is held by rsp_stall
// start transactions load the playback state and give no result
// reset (synchronous, active high) clears the playback state and output valid,
// and returns the loop registers to their reset values
// depends on slag_pkg and sample_loop_address_gen_macros.svh
`include "sample_loop_address_gen_macros.svh"

module sample_loop_address_gen #(
   parameter int ADDR_BITS  = slag_pkg::ADDR_BITS_DEFAULT,
   parameter int COUNT_BITS = slag_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [slag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS:0]                  csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic signed [ADDR_BITS:0]           req_start_position,
   input  logic                                req_backward,
   input  logic [COUNT_BITS-1:0]               req_passes,
   input  logic [COUNT_BITS-1:0]               req_run_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ADDR_BITS:0]           rsp_sample_address,
   output logic                                rsp_in_range,
   output logic                                rsp_last
);
   import slag_pkg::*;

   localparam int POS_BITS = ADDR_BITS + 1;
   localparam int CMP_BITS = ADDR_BITS + 2;
   localparam logic [POS_BITS-1:0]   POS_ONE = POS_BITS'(1);
   localparam logic [CMP_BITS-1:0]   CMP_ONE = CMP_BITS'(1);
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   // loop registers
   logic [MODE_BITS-1:0]    loop_mode_ff;
   logic [ADDR_BITS-1:0]    loop_start_ff;
   logic [ADDR_BITS-1:0]    loop_end_ff;
   logic [CHANNEL_BITS-1:0] channel_count_ff;
   logic [POS_BITS-1:0]     wave_size_ff;

   // playback state
   logic [POS_BITS-1:0]   position_ff, position_in;
   logic                  moving_down_ff, moving_down_in;
   logic [COUNT_BITS-1:0] passes_left_ff, passes_left_in;
   logic [COUNT_BITS-1:0] samples_left_ff, samples_left_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0] rsp_address_ff;
   logic                rsp_in_range_ff;
   logic                rsp_last_ff;

   logic                  req_accept;
   logic                  emit;
   logic [POS_BITS-1:0]   step_pos;
   logic [CMP_BITS-1:0]   step_ext, first_ext, last_ext, chan_ext;
   logic                  hit_low, hit_high, hit_jump;
   logic [POS_BITS-1:0]   adv_pos;
   logic                  adv_down;
   logic [COUNT_BITS-1:0] adv_passes;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff     <= LOOP_NONE;
         loop_start_ff    <= '0;
         loop_end_ff      <= '0;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         wave_size_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOOP_MODE:     loop_mode_ff     <= csr_data[MODE_BITS-1:0];
            CSR_LOOP_START:    loop_start_ff    <= csr_data[ADDR_BITS-1:0];
            CSR_LOOP_END:      loop_end_ff      <= csr_data[ADDR_BITS-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CHANNEL_BITS-1:0];
            CSR_WAVE_SIZE:     wave_size_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign emit       = req_accept && (req_operation == OP_STEP) && (samples_left_ff != '0);

   // edge compares at full precision
   assign step_pos  = moving_down_ff ? position_ff - POS_ONE : position_ff + POS_ONE;
   assign step_ext  = {step_pos[POS_BITS-1], step_pos};
   assign first_ext = {2'b00, loop_start_ff};
   assign last_ext  = {2'b00, loop_end_ff};
   assign chan_ext  = CMP_BITS'(channel_count_ff);
   assign hit_low   = step_ext == first_ext - CMP_ONE;
   assign hit_high  = step_ext == last_ext + CMP_ONE;
   assign hit_jump  = step_ext == last_ext + chan_ext;

   always_comb begin
      adv_pos    = step_pos;
      adv_down   = moving_down_ff;
      adv_passes = passes_left_ff;
      if (passes_left_ff != '0) begin
         case (loop_mode_ff)
            LOOP_PINGPONG: begin
               if (moving_down_ff && hit_low) begin
                  adv_passes = passes_left_ff - CNT_ONE;
                  adv_down   = 1'b0;
                  adv_pos    = {1'b0, loop_start_ff} + POS_ONE;
               end else if (!moving_down_ff && hit_high) begin
                  adv_passes = passes_left_ff - CNT_ONE;
                  adv_down   = 1'b1;
                  adv_pos    = {1'b0, loop_end_ff} - POS_ONE;
               end
            end
            LOOP_JUMP: begin
               if (hit_jump) begin
                  adv_passes = passes_left_ff - CNT_ONE;
                  adv_pos    = {1'b0, loop_start_ff};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      position_in     = position_ff;
      moving_down_in  = moving_down_ff;
      passes_left_in  = passes_left_ff;
      samples_left_in = samples_left_ff;
      if (req_accept && (req_operation == OP_START)) begin
         position_in     = req_start_position;
         moving_down_in  = req_backward;
         passes_left_in  = req_passes;
         samples_left_in = req_run_length;
      end else if (emit) begin
         position_in     = adv_pos;
         moving_down_in  = adv_down;
         passes_left_in  = adv_passes;
         samples_left_in = samples_left_ff - CNT_ONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         moving_down_ff  <= 1'b0;
         passes_left_ff  <= '0;
         samples_left_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         position_ff     <= position_in;
         moving_down_ff  <= moving_down_in;
         passes_left_ff  <= passes_left_in;
         samples_left_ff <= samples_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_address_ff  <= position_ff;
         rsp_in_range_ff <= ~position_ff[POS_BITS-1] && (position_ff < wave_size_ff);
         rsp_last_ff     <= samples_left_ff == CNT_ONE;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_address = rsp_address_ff;
   assign rsp_in_range       = rsp_in_range_ff;
   assign rsp_last           = rsp_last_ff;

   `SLAG_ASSERT_NEXT(a_step_gives_result, clock, reset, !reset && emit, rsp_valid_ff, "step with samples left gave no result")
   `SLAG_ASSERT_NEXT(a_empty_step_holds, clock, reset, !reset && req_accept && (req_operation == OP_STEP) && (samples_left_ff == '0), $stable(position_ff) && $stable(samples_left_ff), "step with no samples left changed the state")
   `SLAG_ASSERT_NEXT(a_passes_count_down, clock, reset, !reset && !(req_accept && (req_operation == OP_START)), (passes_left_ff == $past(passes_left_ff)) || (passes_left_ff == $past(passes_left_ff) - CNT_ONE), "passes left moved by more than one")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// testbench for sample_loop_address_gen: start and step transactions against a
// behavioural playback model, outputs compared in order, field by field
// depends on slag_pkg and the rtl of sample_loop_address_gen
module tb_top;
   import slag_pkg::*;

   localparam int AW          = ADDR_BITS_DEFAULT;
   localparam int CW          = COUNT_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic signed [AW:0]    POS_MAX     = {1'b0, {AW{1'b1}}};
   localparam logic signed [AW:0]    POS_MIN     = {1'b1, {AW{1'b0}}};
   localparam logic [AW:0]           WAVE_FULL   = {1'b1, {AW{1'b0}}};
   localparam logic [MODE_BITS-1:0]  LOOP_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [AW:0] address;
      logic               in_range;
      logic               last;
   } sample_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [AW:0]               csr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_operation;
   logic signed [AW:0]        req_start_position;
   logic                      req_backward;
   logic [CW-1:0]             req_passes;
   logic [CW-1:0]             req_run_length;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [AW:0]        rsp_sample_address;
   logic                      rsp_in_range;
   logic                      rsp_last;

   // model copy of the loop registers and playback state
   logic [MODE_BITS-1:0]      cfg_mode;
   logic [AW-1:0]             cfg_loop_start;
   logic [AW-1:0]             cfg_loop_end;
   logic [CHANNEL_BITS-1:0]   cfg_channels;
   logic [AW:0]               cfg_wave_size;
   logic signed [AW:0]        play_pos;
   logic                      play_down;
   logic [CW-1:0]             passes_left;
   logic [CW-1:0]             samples_left;

   sample_type pending_samples[$];
   sample_type want;
   int      mismatches    = 0;
   int      items_sent    = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      stall_hold    = 0;
   int      cycle_count;

   sample_loop_address_gen dut (.*);

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic predict_playback(input logic op, input logic signed [AW:0] pos,
                                   input logic back, input logic [CW-1:0] passes,
                                   input logic [CW-1:0] len);
      longint  p;
      longint  first;
      longint  last_pos;
      longint  chans;
      longint  wave;
      longint  target;
      sample_type s;
      if (op == OP_START) begin
         play_pos     = pos;
         play_down    = back;
         passes_left  = passes;
         samples_left = len;
      end else if (samples_left != 0) begin
         p          = longint'(play_pos);
         wave       = longint'(cfg_wave_size);
         s.address  = play_pos;
         s.in_range = (p >= 0) && (p < wave);
         s.last     = (samples_left == 1);
         pending_samples.push_back(s);
         samples_left = samples_left - 1'b1;
         play_pos = play_down ? play_pos - 1'b1 : play_pos + 1'b1;
         if (passes_left != 0) begin
            p        = longint'(play_pos);
            first    = longint'(cfg_loop_start);
            last_pos = longint'(cfg_loop_end);
            chans    = longint'(cfg_channels);
            target   = p;
            if (cfg_mode == LOOP_PINGPONG) begin
               if (play_down && p == first - 1) begin
                  passes_left = passes_left - 1'b1;
                  play_down   = 1'b0;
                  target      = first + 1;
               end else if (!play_down && p == last_pos + 1) begin
                  passes_left = passes_left - 1'b1;
                  play_down   = 1'b1;
                  target      = last_pos - 1;
               end
            end else if (cfg_mode == LOOP_JUMP) begin
               if (p == last_pos + chans) begin
                  passes_left = passes_left - 1'b1;
                  target      = first;
               end
            end
            play_pos = target[AW:0];
         end
      end
   endtask

   task automatic send_item(input logic op, input logic signed [AW:0] pos, input logic back,
                            input logic [CW-1:0] passes, input logic [CW-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_operation      = op;
      req_start_position = pos;
      req_backward       = back;
      req_passes         = passes;
      req_run_length     = len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_playback(op, pos, back, passes, len);
      items_sent++;
      @(negedge clock);
   endtask

   // start fields are don't-care on a step, so they carry noise
   task automatic send_step();
      logic [31:0] a;
      logic [31:0] b;
      a = $urandom;
      b = $urandom;
      send_item(OP_STEP, a[AW:0], b[0], b[31:16], a[31:16]);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input logic [AW:0] data);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (index)
         CSR_LOOP_MODE:     cfg_mode       = data[MODE_BITS-1:0];
         CSR_LOOP_START:    cfg_loop_start = data[AW-1:0];
         CSR_LOOP_END:      cfg_loop_end   = data[AW-1:0];
         CSR_CHANNEL_COUNT: cfg_channels   = data[CHANNEL_BITS-1:0];
         CSR_WAVE_SIZE:     cfg_wave_size  = data;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_loop(input logic [MODE_BITS-1:0] mode, input logic [AW:0] first,
                           input logic [AW:0] last_pos, input logic [CHANNEL_BITS-1:0] chans,
                           input logic [AW:0] wave);
      wait_idle();
      write_reg(CSR_LOOP_MODE, {{(AW+1-MODE_BITS){1'b0}}, mode});
      write_reg(CSR_LOOP_START, first);
      write_reg(CSR_LOOP_END, last_pos);
      write_reg(CSR_CHANNEL_COUNT, {{(AW+1-CHANNEL_BITS){1'b0}}, chans});
      write_reg(CSR_WAVE_SIZE, wave);
   endtask

   task automatic test_directed();
      send_step();
      set_loop(LOOP_NONE, 0, 0, CHANNEL_COUNT_RESET, 16);
      send_item(OP_START, -1, 1'b0, 5, 2);
      repeat (3) send_step();
      send_item(OP_START, 3, 1'b0, 0, 0);
      send_step();
      set_loop(LOOP_NONE, 0, 0, CHANNEL_COUNT_RESET, WAVE_FULL);
      send_item(OP_START, POS_MAX, 1'b0, '1, 2);
      repeat (2) send_step();
      send_item(OP_START, POS_MIN, 1'b1, '1, 1);
      send_step();
      set_loop(LOOP_PINGPONG, 4, 6, CHANNEL_COUNT_RESET, 6);
      send_item(OP_START, 5, 1'b0, 2, 6);
      repeat (6) send_step();
      // loop edges reversed and a zero channel count
      set_loop(LOOP_JUMP, 9, 3, 0, 12);
      send_item(OP_START, 2, 1'b0, 2, 3);
      repeat (3) send_step();
      set_loop(LOOP_UNUSED, 4, 6, CHANNEL_COUNT_RESET, 8);
      for (int i = CSR_WAVE_SIZE + 1; i < 2 ** CSR_INDEX_BITS; i++) begin
         write_reg(i[CSR_INDEX_BITS-1:0], '1);
      end
      send_item(OP_START, 6, 1'b0, 3, 2);
      repeat (2) send_step();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_loop(LOOP_PINGPONG, 10, 14, CHANNEL_COUNT_RESET, 12);
      @(posedge clock);
      stall_hold = 60;
      @(negedge clock);
      send_item(OP_START, 12, 1'b1, 3, 40);
      repeat (30) send_step();
      // sender holds off until every sample has drained
      wait_idle();
      send_item(OP_START, 13, 1'b0, 1, 8);
      repeat (8) send_step();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      int                    stop_at;
      int                    steps;
      int                    off;
      longint                pos;
      logic [31:0]           rnd;
      logic [AW:0]           first;
      logic [AW:0]           last_pos;
      logic [AW:0]           wave;
      logic [MODE_BITS-1:0]  mode;
      logic [CW-1:0]         passes;
      logic [CW-1:0]         len;
      logic                  reconfigure;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at       = items_sent + count;
      reconfigure   = 1'b1;
      while (items_sent < stop_at) begin
         if (reconfigure) begin
            rnd = $urandom;
            case ($urandom_range(4))
               0:       first = '0;
               1:       first = '1;
               2:       first = rnd[AW:0];
               default: first = (AW+1)'($urandom_range(40));
            endcase
            rnd = $urandom;
            case ($urandom_range(4))
               0:       last_pos = '0;
               1:       last_pos = '1;
               2:       last_pos = rnd[AW:0];
               default: last_pos = first + (AW+1)'($urandom_range(12));
            endcase
            rnd = $urandom;
            case ($urandom_range(4))
               0:       wave = '0;
               1:       wave = WAVE_FULL;
               2:       wave = rnd[AW:0];
               default: wave = (AW+1)'($urandom_range(60));
            endcase
            mode = MODE_BITS'(($urandom_range(5) == 0) ? $urandom_range(3)
                                                        : $urandom_range(1, 2));
            set_loop(mode, first, last_pos,
                     CHANNEL_BITS'(($urandom_range(7) == 0) ? $urandom_range(15)
                                                            : $urandom_range(1, 8)),
                     wave);
         end
         reconfigure = ($urandom_range(3) == 0);
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               rnd = $urandom;
               send_item(rnd[31], rnd[AW:0], rnd[30], rnd[15:0], rnd[31:16]);
            end
         end else begin
            off = $urandom_range(6);
            rnd = $urandom;
            case ($urandom_range(5))
               0:       pos = longint'(rnd);
               1:       pos = longint'(rnd[0] ? POS_MAX : POS_MIN);
               2, 3:    pos = longint'(cfg_loop_start) + off - 3;
               default: pos = longint'(cfg_loop_end) + off - 3;
            endcase
            case ($urandom_range(4))
               0:       passes = 0;
               1:       passes = rnd[0] ? '1 : rnd[31:16];
               default: passes = CW'($urandom_range(1, 4));
            endcase
            case ($urandom_range(5))
               0:       len = 0;
               1:       len = rnd[CW-1:0];
               default: len = CW'($urandom_range(1, 20));
            endcase
            steps = $urandom_range(0, (len > 28) ? 30 : len + 2);
            send_item(OP_START, pos[AW:0], rnd[1], passes, len);
            repeat (steps) send_step();
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall = 1'b1;
         stall_hold--;
      end else begin
         rsp_stall = ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, expected none, got address %0d",
                     $time, rsp_sample_address);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample_address !== want.address) begin
               mismatches++;
               $display("%0t: sample_address expected %0d got %0d",
                        $time, $signed(want.address), rsp_sample_address);
            end
            if (rsp_in_range !== want.in_range) begin
               mismatches++;
               $display("%0t: in_range expected %0b got %0b", $time, want.in_range, rsp_in_range);
            end
            if (rsp_last !== want.last) begin
               mismatches++;
               $display("%0t: last expected %0b got %0b", $time, want.last, rsp_last);
            end
         end
      end
   end

   // timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_LOOP_MODE;
      csr_data           = '0;
      req_valid          = 1'b0;
      req_operation      = OP_START;
      req_start_position = '0;
      req_backward       = 1'b0;
      req_passes         = '0;
      req_run_length     = '0;
      cfg_mode           = LOOP_NONE;
      cfg_loop_start     = '0;
      cfg_loop_end       = '0;
      cfg_channels       = CHANNEL_COUNT_RESET;
      cfg_wave_size      = '0;
      play_pos           = '0;
      play_down          = 1'b0;
      passes_left        = '0;
      samples_left       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random(80, 0, 0);
      test_random(80, 47, 0);
      test_random(80, 0, 47);
      test_random(80, 29, 29);
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sample_loop_address_gen.f
+incdir+rtl
rtl/slag_pkg.sv
rtl/sample_loop_address_gen.sv
dv/tb_top.sv
